@@ rtl/sce_pkg.sv @@
`timescale 1ns / 1ps
package sce_pkg;

	// Field widths and fixed-point format.
	localparam int WORD_W = 32;
	localparam int REG_W  = 31;
	localparam int FRAC_W = 16;
	localparam int ADDR_W = 4;
	localparam int ACC_W  = 52;

	// Register reset values, unsigned Q15.16.
	localparam logic [REG_W-1:0] GRAVITY_RST   = 31'd655360;
	localparam logic [REG_W-1:0] DRAG_RST      = 31'd131072;
	localparam logic [REG_W-1:0] STIFFNESS_RST = 31'd13107200;
	localparam logic [REG_W-1:0] REST_LEN_RST  = 31'd52429;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_GRAVITY   = 2'd0,
		REG_DRAG      = 2'd1,
		REG_STIFFNESS = 2'd2,
		REG_REST_LEN  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] gravity;
		logic [REG_W-1:0] drag_coeff;
		logic [REG_W-1:0] spring_stiffness;
		logic [REG_W-1:0] rest_length;
	} cfg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pos_x;
		logic signed [WORD_W-1:0] pos_y;
		logic signed [WORD_W-1:0] pos_z;
		logic signed [WORD_W-1:0] vel_x;
		logic signed [WORD_W-1:0] vel_y;
		logic signed [WORD_W-1:0] vel_z;
		logic                     chain_start;
		logic                     chain_end;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] dpos_x;
		logic signed [WORD_W-1:0] dpos_y;
		logic signed [WORD_W-1:0] dpos_z;
		logic signed [WORD_W-1:0] accel_x;
		logic signed [WORD_W-1:0] accel_y;
		logic signed [WORD_W-1:0] accel_z;
		logic                     end_of_chain;
	} out_item_t;

	// Particle class decided at the front.
	typedef enum logic {
		KIND_MASS   = 1'b0,
		KIND_ANCHOR = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic                   last;
		logic [2:0][WORD_W-1:0] pos;
		logic [2:0][WORD_W-1:0] vel;
	} front_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULA,
		ST_ROOT,
		ST_SPRM,
		ST_DIV,
		ST_FMUL,
		ST_FIN,
		ST_EMITA,
		ST_UPD,
		ST_EMITB
	} back_state_t;

endpackage

@@ rtl/sce_front.sv @@
`timescale 1ns / 1ps
module sce_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  sce_pkg::in_item_t    item,
	output logic                 q_valid,
	input  logic                 q_pop,
	output sce_pkg::front_item_t q_item
);

	sce_pkg::front_item_t mem_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           count_q;
	logic                 push;
	logic                 pop;
	sce_pkg::front_item_t cls;

	// Classify the incoming particle.
	always_comb begin
		cls.kind = item.chain_start ? sce_pkg::KIND_ANCHOR : sce_pkg::KIND_MASS;
		cls.last = item.chain_end;
		cls.pos  = {item.pos_z, item.pos_y, item.pos_x};
		cls.vel  = {item.vel_z, item.vel_y, item.vel_x};
	end

	assign item_ready = (count_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign q_valid    = (count_q != 2'd0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[rd_ptr_q];

	// Two-entry queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cls;
	end

endmodule

@@ rtl/sce_back.sv @@
`timescale 1ns / 1ps
module sce_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sce_pkg::cfg_t        cfg,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  sce_pkg::front_item_t q_item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output sce_pkg::out_item_t   result
);

	localparam int W = sce_pkg::WORD_W;
	localparam int A = sce_pkg::ACC_W;

	sce_pkg::back_state_t state_q, state_d;
	logic [4:0]           cnt_q;
	sce_pkg::front_item_t cur_q;

	logic [W-1:0]   dmag_q [3];
	logic           dneg_q [3];
	logic [W-1:0]   vmag_q [3];
	logic           vneg_q [3];
	logic [63:0]    sum_q;
	logic [46:0]    drag_q [3];
	logic [63:0]    x_q;
	logic [63:0]    r_q;
	logic           mneg_q;
	logic [46:0]    m_q;
	logic [W-1:0]   rem_q [3];
	logic [16:0]    u_q [3];
	logic [63:0]    facc_q [3];
	logic           spring_q;
	logic [63:0]    prod_q;
	logic [W-1:0]   accn_q [3];
	logic [W-1:0]   prev_pos_q [3];
	logic [W-1:0]   prev_vel_q [3];
	logic [W-1:0]   prev_acc_q [3];
	logic           prev_anchor_q;
	logic           holding_q;
	sce_pkg::out_item_t res_q;
	logic           res_valid_q;

	logic [W-1:0]   mul_a, mul_b;
	logic [W-1:0]   dmag_n [3];
	logic           dneg_n [3];
	logic [W-1:0]   vmag_n [3];
	logic [63:0]    bitv, trial;
	logic [W:0]     ldiff;
	logic [W-1:0]   ldiff_mag;
	logic [W-1:0]   len;
	logic [W:0]     dsh [3];
	logic           dge [3];
	logic [W-1:0]   accn_n [3];
	logic [W-1:0]   react_n [3];
	logic           out_free;
	logic           emit;

	function automatic logic [W-1:0] sat_word(input logic signed [A-1:0] v);
		logic signed [A-1:0] hi, lo;
		hi = $signed({{(A-W+1){1'b0}}, {(W-1){1'b1}}});
		lo = ~hi;
		if (v > hi) return hi[W-1:0];
		if (v < lo) return lo[W-1:0];
		return v[W-1:0];
	endfunction

	assign len      = r_q[W-1:0];
	assign out_free = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Separation from the held particle, saturated, split into magnitude and sign.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [W:0] df;
			logic [W-1:0]      ds;
			df = $signed({q_item.pos[i][W-1], q_item.pos[i]})
			     - $signed({prev_pos_q[i][W-1], prev_pos_q[i]});
			if (df[W] != df[W-1]) ds = {df[W], {(W-1){~df[W]}}};
			else ds = df[W-1:0];
			dneg_n[i] = ds[W-1];
			dmag_n[i] = ds[W-1] ? W'(-ds) : ds;
			vmag_n[i] = q_item.vel[i][W-1] ? W'(-q_item.vel[i]) : q_item.vel[i];
		end
	end

	// Root and spring length terms.
	always_comb begin
		bitv      = 64'd1 << (6'd62 - {cnt_q, 1'b0});
		trial     = r_q + bitv;
		ldiff     = {1'b0, len} - {2'b0, cfg.rest_length};
		ldiff_mag = ldiff[W] ? W'(-ldiff) : ldiff[W-1:0];
	end

	// Restoring division lanes for the unit direction.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsh[i] = {rem_q[i], (cnt_q == 5'd0) ? dmag_q[i][0] : 1'b0};
			dge[i] = dsh[i] >= {1'b0, len};
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			sce_pkg::ST_MULA: begin
				case (cnt_q)
					5'd0: begin mul_a = dmag_q[0]; mul_b = dmag_q[0]; end
					5'd1: begin mul_a = dmag_q[1]; mul_b = dmag_q[1]; end
					5'd2: begin mul_a = dmag_q[2]; mul_b = dmag_q[2]; end
					5'd3: begin mul_a = {1'b0, cfg.drag_coeff}; mul_b = vmag_q[0]; end
					5'd4: begin mul_a = {1'b0, cfg.drag_coeff}; mul_b = vmag_q[1]; end
					5'd5: begin mul_a = {1'b0, cfg.drag_coeff}; mul_b = vmag_q[2]; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			sce_pkg::ST_SPRM: begin
				mul_a = {1'b0, cfg.spring_stiffness};
				mul_b = ldiff_mag;
			end
			sce_pkg::ST_FMUL: begin
				case (cnt_q)
					5'd0: begin mul_a = m_q[31:0]; mul_b = {15'd0, u_q[0]}; end
					5'd1: begin mul_a = {17'd0, m_q[46:32]}; mul_b = {15'd0, u_q[0]}; end
					5'd2: begin mul_a = m_q[31:0]; mul_b = {15'd0, u_q[1]}; end
					5'd3: begin mul_a = {17'd0, m_q[46:32]}; mul_b = {15'd0, u_q[1]}; end
					5'd4: begin mul_a = m_q[31:0]; mul_b = {15'd0, u_q[2]}; end
					5'd5: begin mul_a = {17'd0, m_q[46:32]}; mul_b = {15'd0, u_q[2]}; end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Acceleration of the current particle and reaction on the held one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic signed [A-1:0] g, dr, fv;
			g  = (i == 1) ? -$signed({{(A-sce_pkg::REG_W){1'b0}}, cfg.gravity}) : '0;
			dr = $signed({{(A-47){1'b0}}, drag_q[i]});
			dr = vneg_q[i] ? dr : -dr;
			fv = $signed({{(A-48){1'b0}}, facc_q[i][63:16]});
			if (!spring_q) fv = '0;
			else if (!(mneg_q ^ dneg_q[i])) fv = -fv;
			accn_n[i]  = sat_word(g + dr + fv);
			react_n[i] = sat_word($signed({{(A-W){prev_acc_q[i][W-1]}}, prev_acc_q[i]}) - fv);
		end
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		case (state_q)
			sce_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.kind == sce_pkg::KIND_ANCHOR)
						state_d = holding_q ? sce_pkg::ST_EMITA : sce_pkg::ST_UPD;
					else
						state_d = sce_pkg::ST_MULA;
				end
			end
			sce_pkg::ST_MULA: begin
				if (cnt_q == 5'd6) state_d = holding_q ? sce_pkg::ST_ROOT : sce_pkg::ST_FIN;
			end
			sce_pkg::ST_ROOT: begin
				if (cnt_q == 5'd31) state_d = sce_pkg::ST_SPRM;
			end
			sce_pkg::ST_SPRM: begin
				if (cnt_q == 5'd0 && len == '0) state_d = sce_pkg::ST_FIN;
				else if (cnt_q == 5'd1) state_d = sce_pkg::ST_DIV;
			end
			sce_pkg::ST_DIV: begin
				if (cnt_q == 5'd16) state_d = sce_pkg::ST_FMUL;
			end
			sce_pkg::ST_FMUL: begin
				if (cnt_q == 5'd6) state_d = sce_pkg::ST_FIN;
			end
			sce_pkg::ST_FIN: begin
				state_d = holding_q ? sce_pkg::ST_EMITA : sce_pkg::ST_UPD;
			end
			sce_pkg::ST_EMITA: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = sce_pkg::ST_UPD;
				end
			end
			sce_pkg::ST_UPD: begin
				state_d = cur_q.last ? sce_pkg::ST_EMITB : sce_pkg::ST_IDLE;
			end
			sce_pkg::ST_EMITB: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = sce_pkg::ST_IDLE;
				end
			end
			default: state_d = sce_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sce_pkg::ST_IDLE;
			cnt_q         <= '0;
			holding_q     <= 1'b0;
			prev_anchor_q <= 1'b0;
			res_valid_q   <= 1'b0;
			spring_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? 5'd0 : cnt_q + 5'd1;
			if (emit) res_valid_q <= 1'b1;
			else if (result_ready) res_valid_q <= 1'b0;
			if (state_q == sce_pkg::ST_IDLE) spring_q <= 1'b0;
			if (state_q == sce_pkg::ST_FMUL && cnt_q == 5'd6) spring_q <= 1'b1;
			if (state_q == sce_pkg::ST_UPD) begin
				holding_q     <= 1'b1;
				prev_anchor_q <= (cur_q.kind == sce_pkg::KIND_ANCHOR);
			end
			if (state_q == sce_pkg::ST_EMITB && out_free) holding_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			sce_pkg::ST_IDLE: begin
				cur_q <= q_item;
				sum_q <= '0;
				for (int i = 0; i < 3; i++) begin
					dmag_q[i] <= dmag_n[i];
					dneg_q[i] <= dneg_n[i];
					vmag_q[i] <= vmag_n[i];
					vneg_q[i] <= q_item.vel[i][W-1];
				end
			end
			sce_pkg::ST_MULA: begin
				case (cnt_q)
					5'd1, 5'd2, 5'd3: sum_q <= sum_q + prod_q;
					5'd4: drag_q[0] <= prod_q[62:16];
					5'd5: drag_q[1] <= prod_q[62:16];
					5'd6: drag_q[2] <= prod_q[62:16];
					default: sum_q <= sum_q;
				endcase
				x_q <= sum_q;
				r_q <= '0;
			end
			sce_pkg::ST_ROOT: begin
				if (x_q >= trial) begin
					x_q <= x_q - trial;
					r_q <= (r_q >> 1) + bitv;
				end else begin
					r_q <= r_q >> 1;
				end
			end
			sce_pkg::ST_SPRM: begin
				if (cnt_q == 5'd0) mneg_q <= ldiff[W];
				m_q <= prod_q[62:16];
				for (int i = 0; i < 3; i++) rem_q[i] <= dmag_q[i] >> 1;
			end
			sce_pkg::ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= dge[i] ? W'(dsh[i] - {1'b0, len}) : dsh[i][W-1:0];
					u_q[i]   <= {u_q[i][15:0], dge[i]};
				end
			end
			sce_pkg::ST_FMUL: begin
				case (cnt_q)
					5'd1: facc_q[0] <= prod_q;
					5'd2: facc_q[0] <= facc_q[0] + {prod_q[31:0], 32'd0};
					5'd3: facc_q[1] <= prod_q;
					5'd4: facc_q[1] <= facc_q[1] + {prod_q[31:0], 32'd0};
					5'd5: facc_q[2] <= prod_q;
					5'd6: facc_q[2] <= facc_q[2] + {prod_q[31:0], 32'd0};
					default: facc_q[0] <= facc_q[0];
				endcase
			end
			sce_pkg::ST_FIN: begin
				for (int i = 0; i < 3; i++) begin
					accn_q[i] <= accn_n[i];
					if (holding_q && !prev_anchor_q) prev_acc_q[i] <= react_n[i];
				end
			end
			sce_pkg::ST_UPD: begin
				for (int i = 0; i < 3; i++) begin
					prev_pos_q[i] <= cur_q.pos[i];
					if (cur_q.kind == sce_pkg::KIND_ANCHOR) begin
						prev_vel_q[i] <= '0;
						prev_acc_q[i] <= '0;
					end else begin
						prev_vel_q[i] <= cur_q.vel[i];
						prev_acc_q[i] <= accn_q[i];
					end
				end
			end
			default: ;
		endcase
		// Results always come from the held particle registers.
		if (emit) begin
			res_q.dpos_x       <= prev_vel_q[0];
			res_q.dpos_y       <= prev_vel_q[1];
			res_q.dpos_z       <= prev_vel_q[2];
			res_q.accel_x      <= prev_acc_q[0];
			res_q.accel_y      <= prev_acc_q[1];
			res_q.accel_z      <= prev_acc_q[2];
			res_q.end_of_chain <= (state_q == sce_pkg::ST_EMITB);
		end
	end

endmodule

@@ rtl/spring_chain_force_eval_core.sv @@
`timescale 1ns / 1ps
// Back-end: an anchor releases any held particle, then is held. A particle with no predecessor
// runs squares and drag, finishes and updates; one with a predecessor runs squares and drag,
// square root, spring magnitude, division, force products, finish, release and update, skipping
// division and products at zero length. A chain end adds an emit step; emits stall on result.
// Throughput: one particle at a time; a two-entry registered queue accepts input meanwhile.
// Reset clears the sequencer, the queue and the held particle, and loads register defaults.
module spring_chain_force_eval_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  sce_pkg::in_item_t             item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output sce_pkg::out_item_t            result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sce_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	sce_pkg::cfg_t        cfg_q;
	sce_pkg::reg_idx_t    reg_idx;
	logic                 q_valid;
	logic                 q_pop;
	sce_pkg::front_item_t q_item;

	assign pready  = 1'b1;
	assign reg_idx = sce_pkg::reg_idx_t'(paddr[3:2]);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gravity          <= sce_pkg::GRAVITY_RST;
			cfg_q.drag_coeff       <= sce_pkg::DRAG_RST;
			cfg_q.spring_stiffness <= sce_pkg::STIFFNESS_RST;
			cfg_q.rest_length      <= sce_pkg::REST_LEN_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				sce_pkg::REG_GRAVITY:   cfg_q.gravity          <= pwdata[30:0];
				sce_pkg::REG_DRAG:      cfg_q.drag_coeff       <= pwdata[30:0];
				sce_pkg::REG_STIFFNESS: cfg_q.spring_stiffness <= pwdata[30:0];
				sce_pkg::REG_REST_LEN:  cfg_q.rest_length      <= pwdata[30:0];
				default:                cfg_q                  <= cfg_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			sce_pkg::REG_GRAVITY:   prdata = {1'b0, cfg_q.gravity};
			sce_pkg::REG_DRAG:      prdata = {1'b0, cfg_q.drag_coeff};
			sce_pkg::REG_STIFFNESS: prdata = {1'b0, cfg_q.spring_stiffness};
			sce_pkg::REG_REST_LEN:  prdata = {1'b0, cfg_q.rest_length};
			default:                prdata = '0;
		endcase
	end

	sce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item)
	);

	sce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_item       (q_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ bench/sce_checker.sv @@
`timescale 1ns / 1ps
// Watches the item, result and configuration channels, predicts every result beat
// and compares it field by field with the oldest prediction.
module sce_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  logic                       item_ready,
	input  sce_pkg::in_item_t          item,
	input  logic                       result_valid,
	input  logic                       result_ready,
	input  sce_pkg::out_item_t         result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [sce_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output int                         mismatches,
	output int                         pending,
	output int                         results_seen
);

	localparam longint WORD_MAX = 64'sh7FFFFFFF;
	localparam longint WORD_MIN = -64'sh80000000;

	// Shadow copy of the registers and of the held particle.
	logic [sce_pkg::REG_W-1:0] gravity_q, drag_q, stiffness_q, rest_len_q;
	longint                    held_pos [3];
	longint                    held_vel [3];
	longint                    held_acc [3];
	bit                        held_is_anchor, holding;
	sce_pkg::out_item_t        derivs_q[$];

	assign pending = derivs_q.size();

	function automatic longint clamp_word(longint v);
		if (v > WORD_MAX) return WORD_MAX;
		if (v < WORD_MIN) return WORD_MIN;
		return v;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	// Q16.16 product on magnitudes, truncated toward zero, then signed.
	function automatic longint fx_mul(longint a, longint b);
		longint unsigned p;
		p = (magnitude(a) * magnitude(b)) >> 16;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic sce_pkg::out_item_t make_deriv(longint dp [3], longint ac [3], bit last);
		sce_pkg::out_item_t o;
		o.dpos_x = dp[0][31:0];
		o.dpos_y = dp[1][31:0];
		o.dpos_z = dp[2][31:0];
		o.accel_x = ac[0][31:0];
		o.accel_y = ac[1][31:0];
		o.accel_z = ac[2][31:0];
		o.end_of_chain = last;
		return o;
	endfunction

	// Append one expected beat at the tail of the prediction queue.
	task automatic expect_beat(sce_pkg::out_item_t o);
		derivs_q = {derivs_q, o};
	endtask

	// Advance the chain state by one particle and queue the results it releases.
	task automatic predict_particle(sce_pkg::in_item_t x);
		longint           p [3];
		longint           v [3];
		longint           a [3];
		longint           f [3];
		longint           d [3];
		longint           zero [3];
		longint           m, u, g;
		longint unsigned  sq, len;
		p[0] = x.pos_x; p[1] = x.pos_y; p[2] = x.pos_z;
		v[0] = x.vel_x; v[1] = x.vel_y; v[2] = x.vel_z;
		for (int i = 0; i < 3; i++) begin
			f[i] = 0;
			zero[i] = 0;
		end
		// A new anchor flushes whatever is held and becomes the held particle.
		if (x.chain_start) begin
			if (holding) expect_beat(make_deriv(held_vel, held_acc, 1'b0));
			for (int i = 0; i < 3; i++) begin
				held_pos[i] = p[i];
				held_vel[i] = 0;
				held_acc[i] = 0;
			end
			held_is_anchor = 1'b1;
			holding = 1'b1;
			if (x.chain_end) begin
				expect_beat(make_deriv(zero, zero, 1'b1));
				holding = 1'b0;
			end
			return;
		end
		// Spring force toward the predecessor; zero length gives no force.
		if (holding) begin
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				d[i] = clamp_word(p[i] - held_pos[i]);
				sq = sq + magnitude(d[i]) * magnitude(d[i]);
			end
			len = int_sqrt(sq);
			if (len != 0) begin
				m = fx_mul(longint'(stiffness_q), longint'(len) - longint'(rest_len_q));
				for (int i = 0; i < 3; i++) begin
					u = longint'((magnitude(d[i]) << 16) / len);
					if (d[i] < 0) u = -u;
					f[i] = -fx_mul(m, u);
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			g = (i == 1) ? -longint'(gravity_q) : 0;
			a[i] = clamp_word(g - fx_mul(longint'(drag_q), v[i]) + f[i]);
		end
		// The reaction goes to the predecessor unless it is an anchor; the predecessor is then released.
		if (holding) begin
			if (!held_is_anchor)
				for (int i = 0; i < 3; i++) held_acc[i] = clamp_word(held_acc[i] - f[i]);
			expect_beat(make_deriv(held_vel, held_acc, 1'b0));
		end
		for (int i = 0; i < 3; i++) begin
			held_pos[i] = p[i];
			held_vel[i] = v[i];
			held_acc[i] = a[i];
		end
		held_is_anchor = 1'b0;
		holding = 1'b1;
		if (x.chain_end) begin
			expect_beat(make_deriv(held_vel, held_acc, 1'b1));
			holding = 1'b0;
		end
	endtask

	task automatic compare_deriv(sce_pkg::out_item_t got);
		sce_pkg::out_item_t want;
		if (derivs_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: unexpected result beat %p", $realtime, got);
			return;
		end
		want = derivs_q.pop_front();
		if (got.dpos_x !== want.dpos_x || got.dpos_y !== want.dpos_y ||
				got.dpos_z !== want.dpos_z || got.accel_x !== want.accel_x ||
				got.accel_y !== want.accel_y || got.accel_z !== want.accel_z ||
				got.end_of_chain !== want.end_of_chain) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: result mismatch", $realtime);
				$display("  expected %p", want);
				$display("  actual   %p", got);
			end
		end
	endtask

	// Sample all channels on the clock; item beats are predicted before results are popped.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= sce_pkg::GRAVITY_RST;
			drag_q <= sce_pkg::DRAG_RST;
			stiffness_q <= sce_pkg::STIFFNESS_RST;
			rest_len_q <= sce_pkg::REST_LEN_RST;
			for (int i = 0; i < 3; i++) begin
				held_pos[i] = 0;
				held_vel[i] = 0;
				held_acc[i] = 0;
			end
			held_is_anchor = 1'b0;
			holding = 1'b0;
			derivs_q.delete();
			mismatches = 0;
			results_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (sce_pkg::reg_idx_t'(paddr[3:2]))
					sce_pkg::REG_GRAVITY: gravity_q <= pwdata[sce_pkg::REG_W-1:0];
					sce_pkg::REG_DRAG: drag_q <= pwdata[sce_pkg::REG_W-1:0];
					sce_pkg::REG_STIFFNESS: stiffness_q <= pwdata[sce_pkg::REG_W-1:0];
					sce_pkg::REG_REST_LEN: rest_len_q <= pwdata[sce_pkg::REG_W-1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) predict_particle(item);
			if (result_valid && result_ready) begin
				results_seen++;
				compare_deriv(result);
			end
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

	logic                       clk;
	logic                       arst_n;
	logic                       item_valid;
	logic                       item_ready;
	sce_pkg::in_item_t          item;
	logic                       result_valid;
	logic                       result_ready;
	sce_pkg::out_item_t         result;
	logic                       psel, penable, pwrite;
	logic [sce_pkg::ADDR_W-1:0] paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	int                         mismatches, pending, results_seen;
	int                         tx_idle_pct, rx_idle_pct;
	int                         particles_sent, chains_sent;

	spring_chain_force_eval_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sce_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.mismatches(mismatches), .pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop well past the slowest correct run.
	initial begin
		#4ms;
		$display("Test completed with failures");
		$finish;
	end

	// Receiver back-pressure.
	always @(posedge clk) result_ready <= ($urandom_range(99) >= rx_idle_pct);

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(1) ? 32'h0 : 32'hFFFFFFFF;
			3, 4: return $urandom();
			default: return $urandom_range(32'h3FFFF) - 32'h20000;
		endcase
	endfunction

	function automatic sce_pkg::in_item_t particle(logic [31:0] px, py, pz, vx, vy, vz,
			logic first, logic last);
		sce_pkg::in_item_t x;
		x.pos_x = px; x.pos_y = py; x.pos_z = pz;
		x.vel_x = vx; x.vel_y = vy; x.vel_z = vz;
		x.chain_start = first;
		x.chain_end = last;
		return x;
	endfunction

	task automatic send(sce_pkg::in_item_t x);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		particles_sent++;
	endtask

	task automatic reg_write(sce_pkg::reg_idx_t idx, logic [sce_pkg::REG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= sce_pkg::ADDR_W'({idx, 2'b00});
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Stop sending until every predicted result has arrived, then let the core settle.
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic set_regs(logic [sce_pkg::REG_W-1:0] g, dr, k, rl);
		reg_write(sce_pkg::REG_GRAVITY, g);
		reg_write(sce_pkg::REG_DRAG, dr);
		reg_write(sce_pkg::REG_STIFFNESS, k);
		reg_write(sce_pkg::REG_REST_LEN, rl);
	endtask

	// Mostly well-formed chains whose links are close, plus stray and broken sequences.
	task automatic random_chains(int count);
		logic [31:0] px, py, pz;
		int          links, kind, stop;
		stop = particles_sent + count;
		while (particles_sent < stop) begin
			kind = $urandom_range(9);
			if (kind == 8) begin
				send(particle(pick_word(), pick_word(), pick_word(), pick_word(),
					pick_word(), pick_word(), 1'b0, 1'($urandom_range(1))));
			end else begin
				px = pick_word(); py = pick_word(); pz = pick_word();
				links = (kind == 9) ? $urandom_range(0, 2) : $urandom_range(1, 6);
				send(particle(px, py, pz, pick_word(), pick_word(), pick_word(), 1'b1,
					(links == 0) && $urandom_range(1)));
				for (int i = 0; i < links; i++) begin
					if ($urandom_range(5) == 0) begin
						px = pick_word(); py = pick_word(); pz = pick_word();
					end else begin
						px = px + $urandom_range(32'h3FFFF) - 32'h20000;
						py = py - $urandom_range(32'h1FFFF);
						pz = pz + $urandom_range(32'h3FFFF) - 32'h20000;
					end
					send(particle(px, py, pz, pick_word(), pick_word(), pick_word(), 1'b0,
						(kind != 9) && (i == links - 1)));
				end
				chains_sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tx_idle_pct = 12;
		rx_idle_pct = 50;
		particles_sent = 0;
		chains_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a particle with no predecessor, zero length, saturated offsets,
		// extreme velocities, a new chain while one is held, and a lone anchor.
		send(particle(32'h10000, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 1'b0));
		send(particle(32'h0, 32'h0, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h0, 1'b0, 1'b1));
		send(particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
		send(particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
		send(particle(32'h0, 32'hFFFF3333, 32'h0, 32'h10000, 32'h0, 32'h0, 1'b0, 1'b0));
		send(particle(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 1'b0, 1'b0));
		send(particle(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 1'b0, 1'b0));
		send(particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
		send(particle(32'h5, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1));
		send(particle(32'h12345678, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1));
		send(particle(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0));
		send(particle(32'h0, 32'hFFFF0000, 32'h0, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b0, 1'b0));
		send(particle(32'h0, 32'hFFFE0000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b1));
		random_chains(400);
		drain();

		// Extreme register settings, sender and receiver idling swapped.
		tx_idle_pct = 50;
		rx_idle_pct = 12;
		set_regs(31'h7FFFFFFF, 31'h0, 31'h7FFFFFFF, 31'h0);
		random_chains(400);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_regs(31'h0, 31'h7FFFFFFF, 31'h1, 31'h7FFFFFFF);
		random_chains(200);
		drain();
		set_regs(31'd327680, 31'd65536, 31'd6553600, 31'd65536);
		random_chains(240);
		drain();

		$display("Sent %0d particles in %0d chains under four register settings;",
			particles_sent, chains_sent);
		$display("checked %0d result beats.", results_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
